### rtl/bsee_pkg.sv
package bsee_pkg;

  // element width and default run capacity
  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // controller states
  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_READ0,
    ST_FIRST,
    ST_SCAN,
    ST_END,
    ST_OUT_READ,
    ST_OUT_SEND
  } state_t;

  // memory write data source
  typedef enum logic [1:0] {
    WR_INPUT,
    WR_MIN,
    WR_CARRY
  } wsel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  we;
    wsel_t wsel;
    logic  re;
    logic  load_carry;
    logic  scan;
  } cmd_t;

endpackage

### rtl/bsee_datapath.sv
module bsee_datapath #(
  parameter int MAX_ITEMS = bsee_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  bsee_pkg::cmd_t                    cmd,
  input  logic [$clog2(MAX_ITEMS)-1:0]      waddr,
  input  logic [$clog2(MAX_ITEMS)-1:0]      raddr,
  input  logic [bsee_pkg::DATA_W-1:0]       in_value,
  output logic [bsee_pkg::DATA_W-1:0]       rd_value,
  output logic                              greater
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic [bsee_pkg::DATA_W-1:0] mem [MAX_ITEMS];
  logic [bsee_pkg::DATA_W-1:0] rdata;
  logic [bsee_pkg::DATA_W-1:0] carry;
  logic [bsee_pkg::DATA_W-1:0] carry_next;
  logic [bsee_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]               waddr_q;

  assign waddr_q = waddr;

  // signed compare of the carried element against the fresh read
  assign greater = $signed(carry) > $signed(rdata);

  // write data select: new element, smaller of pair, or carried maximum
  always_comb begin
    case (cmd.wsel)
      bsee_pkg::WR_INPUT: wdata = in_value;
      bsee_pkg::WR_MIN:   wdata = greater ? rdata : carry;
      bsee_pkg::WR_CARRY: wdata = carry;
      default:            wdata = in_value;
    endcase
  end

  // carried element: larger of each compared pair bubbles forward
  always_comb begin
    carry_next = carry;
    if (cmd.load_carry) begin
      carry_next = rdata;
    end else if (cmd.scan) begin
      carry_next = greater ? carry : rdata;
    end
  end

  always_ff @(posedge clk) begin
    carry <= carry_next;
  end

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata <= mem[raddr];
    end
  end

  assign rd_value = rdata;

endmodule

### rtl/bsee_ctrl.sv
module bsee_ctrl #(
  parameter int MAX_ITEMS = bsee_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic                              m_tlast,
  output logic                              m_tuser,
  input  logic                              greater,
  output bsee_pkg::cmd_t                    cmd,
  output logic [$clog2(MAX_ITEMS)-1:0]      waddr,
  output logic [$clog2(MAX_ITEMS)-1:0]      raddr,
  output logic [$clog2(MAX_ITEMS+1)-1:0]    count_out
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  bsee_pkg::state_t state;
  bsee_pkg::state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic          ovf_next;
  logic [AW-1:0] span;
  logic [AW-1:0] span_next;
  logic [AW-1:0] k;
  logic [AW-1:0] k_next;
  logic          swapped;
  logic          swapped_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic          room;
  logic          out_last;

  assign room      = count < CW'(MAX_ITEMS);
  assign out_last  = (CW'(idx) + CW'(1)) == count;
  assign count_out = count;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bsee_pkg::ST_COLLECT;
      count   <= '0;
      ovf     <= 1'b0;
      span    <= '0;
      k       <= '0;
      swapped <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      span    <= span_next;
      k       <= k_next;
      swapped <= swapped_next;
      idx     <= idx_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    span_next      = span;
    k_next         = k;
    swapped_next   = swapped;
    idx_next       = idx;
    cmd.we         = 1'b0;
    cmd.wsel       = bsee_pkg::WR_INPUT;
    cmd.re         = 1'b0;
    cmd.load_carry = 1'b0;
    cmd.scan       = 1'b0;
    waddr          = count[AW-1:0];
    raddr          = '0;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    m_tlast        = 1'b0;
    m_tuser        = 1'b0;
    unique case (state)
      bsee_pkg::ST_COLLECT: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.we     = room;
          count_next = count + CW'(room);
          ovf_next   = ovf | ~room;
          if (s_tlast) begin
            if (count == '0) begin
              idx_next   = '0;
              state_next = bsee_pkg::ST_OUT_READ;
            end else begin
              span_next  = room ? count[AW-1:0] : AW'(MAX_ITEMS - 1);
              state_next = bsee_pkg::ST_READ0;
            end
          end
        end
      end
      bsee_pkg::ST_READ0: begin
        cmd.re       = 1'b1;
        raddr        = '0;
        swapped_next = 1'b0;
        k_next       = '0;
        state_next   = bsee_pkg::ST_FIRST;
      end
      bsee_pkg::ST_FIRST: begin
        cmd.load_carry = 1'b1;
        cmd.re         = 1'b1;
        raddr          = AW'(1);
        state_next     = bsee_pkg::ST_SCAN;
      end
      bsee_pkg::ST_SCAN: begin
        // compare carry with element k+1, write the smaller to k
        cmd.scan     = 1'b1;
        cmd.we       = 1'b1;
        cmd.wsel     = bsee_pkg::WR_MIN;
        waddr        = k;
        swapped_next = swapped | greater;
        if (k + AW'(1) == span) begin
          state_next = bsee_pkg::ST_END;
        end else begin
          cmd.re = 1'b1;
          raddr  = k + AW'(2);
          k_next = k + AW'(1);
        end
      end
      bsee_pkg::ST_END: begin
        // pass maximum lands at the end of the scanned range
        cmd.we   = 1'b1;
        cmd.wsel = bsee_pkg::WR_CARRY;
        waddr    = span;
        if (!swapped || span == AW'(1)) begin
          idx_next   = '0;
          state_next = bsee_pkg::ST_OUT_READ;
        end else begin
          span_next  = span - AW'(1);
          state_next = bsee_pkg::ST_READ0;
        end
      end
      bsee_pkg::ST_OUT_READ: begin
        cmd.re     = 1'b1;
        raddr      = idx;
        state_next = bsee_pkg::ST_OUT_SEND;
      end
      bsee_pkg::ST_OUT_SEND: begin
        m_tvalid = 1'b1;
        m_tlast  = out_last;
        m_tuser  = ovf;
        if (m_tready) begin
          if (out_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = bsee_pkg::ST_COLLECT;
          end else begin
            // prefetch the next element so one request moves per cycle while m_tready is high
            cmd.re   = 1'b1;
            raddr    = idx + AW'(1);
            idx_next = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = bsee_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

### rtl/bubble_sort_early_exit_unit.sv
// Collect: the store write port takes one element per cycle.
// Sort: a pass over a span of s compares does one compare per cycle, using the store's
//   write and read ports together; at most n - 1 passes, fewer on an early exit.
// Output: the first element is read from the store, then one result per cycle while m_tready is high.
// Reset (rst, synchronous, active high) clears the state machine, the element count and
//   the overflow flag; the element store keeps its contents and is never cleared.
module bubble_sort_early_exit_unit #(
  parameter int MAX_ITEMS = bsee_pkg::MAX_ITEMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bsee_pkg::DATA_W-1:0] s_tdata,   // [31:0] item_value
  input  logic                        s_tlast,   // last_item
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bsee_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                        m_tlast,   // last_result
  output logic                        m_tuser    // [0] truncated
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  bsee_pkg::cmd_t cmd;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [CW-1:0]  count;
  logic           greater;

  // run control
  bsee_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .greater   (greater),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr),
    .count_out (count)
  );

  // element store and compare/swap
  bsee_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .waddr    (waddr),
    .raddr    (raddr),
    .in_value (s_tdata),
    .rd_value (m_tdata),
    .greater  (greater)
  );

`ifndef SYNTHESIS
  // input and output phases never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output phases overlap");

  // block returns to collecting right after the final result
  a_back_to_collect: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not collecting after final result");

  // no read of the entry being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.we && cmd.re |-> waddr != raddr)
    else $error("read and write hit the same entry");

  // a result is only offered when the run holds elements
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> count != '0 && count <= CW'(MAX_ITEMS))
    else $error("result offered with bad element count");
`endif

endmodule
